// File: src/sdas_pkg.sv
// Shared types, constants and codes for the signed decimal add/subtract block.
package sdas_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [1:0] MODE_COMPUTE     = 2'd2;

  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [4:0] RADIX     = 5'd10;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] digit;
    logic       first_negative;
    logic       second_negative;
    logic       subtract;
  } in_item_t;

  typedef struct packed {
    logic [3:0] result_digit;
    logic       negative;
    logic       last;
    logic       overflowed;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST,
    CMD_LOAD_SECOND,
    CMD_COMPUTE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [3:0] digit;
    logic       first_negative;
    logic       second_negative;
    logic       subtract;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMP_RD,
    ST_CMP_USE,
    ST_ARI_RD,
    ST_ARI_USE,
    ST_EMIT_START,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_EMIT_ZERO
  } back_state_e;

endpackage

// File: src/sdas_front.sv
// Input stage: accepts items, saturates digits, drops unused modes, forms commands.
module sdas_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sdas_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output sdas_pkg::cmd_t    q_cmd_o
);
  import sdas_pkg::*;

  logic cmd_valid_q, cmd_valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;
  logic is_cmd;

  always_comb begin
    in_stall_o = cmd_valid_q && q_full_i;
    q_push_o   = cmd_valid_q && !q_full_i;
    q_cmd_o    = cmd_q;
    take       = in_valid_i && !in_stall_o;

    is_cmd                = 1'b1;
    cmd_d                 = cmd_q;
    cmd_d.digit           = (in_item_i.digit > DIGIT_MAX) ? DIGIT_MAX : in_item_i.digit;
    cmd_d.first_negative  = in_item_i.first_negative;
    cmd_d.second_negative = in_item_i.second_negative;
    cmd_d.subtract        = in_item_i.subtract;
    case (in_item_i.mode)
      MODE_LOAD_FIRST:  cmd_d.kind = CMD_LOAD_FIRST;
      MODE_LOAD_SECOND: cmd_d.kind = CMD_LOAD_SECOND;
      MODE_COMPUTE:     cmd_d.kind = CMD_COMPUTE;
      default: begin
        cmd_d.kind = CMD_COMPUTE;
        is_cmd     = 1'b0;
      end
    endcase
    if (!take) begin
      cmd_d = cmd_q;
    end

    if (take) begin
      cmd_valid_d = is_cmd;
    end else if (q_push_o) begin
      cmd_valid_d = 1'b0;
    end else begin
      cmd_valid_d = cmd_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// File: src/sdas_queue.sv
// Two-entry command queue between the front and back stages.
module sdas_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdas_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sdas_pkg::cmd_t cmd_o
);
  import sdas_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  always_comb begin
    full_o  = (count_q == 2'd2);
    empty_o = (count_q == 2'd0);
    cmd_o   = entry_q[rd_ptr_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: src/sdas_back.sv
// Execution stage: digit stores, compare, add or subtract, and result emission.
module sdas_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  sdas_pkg::cmd_t     q_cmd_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sdas_pkg::out_item_t out_item_o
);
  import sdas_pkg::*;

  back_state_e state_q, state_d;

  logic [3:0] first_mem  [MAX_DIGITS];
  logic [3:0] second_mem [MAX_DIGITS];
  logic [3:0] result_mem [MAX_DIGITS];

  logic [ADDR_W-1:0] p_q, p_d;
  logic [LEN_W-1:0]  flen_q, flen_d, slen_q, slen_d;
  logic [LEN_W-1:0]  wflen_q, wflen_d, wslen_q, wslen_d, n_q, n_d;
  logic              dropped_q, dropped_d;
  logic              fneg_q, fneg_d, eff_sub_q, eff_sub_d, ovf_q, ovf_d;
  logic              first_larger_q, first_larger_d;
  logic              carry_q, carry_d, nonzero_q, nonzero_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  logic [3:0]        f_rd_q, s_rd_q, r_rd_q;
  logic              f_in_q, s_in_q;

  logic [LEN_W-1:0]  p_ext, f_off, s_off, r_off, n_minus1;
  logic [ADDR_W-1:0] f_addr, s_addr, r_wr_addr;
  logic              f_in, s_in;
  logic              f_we, s_we, r_we;
  logic [3:0]        r_wr_data;
  logic [ADDR_W-1:0] ld_addr;
  logic [3:0]        a_dig, b_dig, hi_dig, lo_dig;
  logic [4:0]        sum, sb;
  logic [3:0]        step_digit;
  logic              step_carry;
  logic              out_free, out_load;
  logic              res_neg, all_zero;
  logic [LEN_W-1:0]  max_len;

  always_comb begin
    p_ext     = {{(LEN_W-ADDR_W){1'b0}}, p_q};
    f_off     = wflen_q - LEN_W'(1) - p_ext;
    s_off     = wslen_q - LEN_W'(1) - p_ext;
    n_minus1  = n_q - LEN_W'(1);
    r_off     = n_minus1 - p_ext;
    f_addr    = f_off[ADDR_W-1:0];
    s_addr    = s_off[ADDR_W-1:0];
    r_wr_addr = r_off[ADDR_W-1:0];
    f_in      = p_ext < wflen_q;
    s_in      = p_ext < wslen_q;
    max_len   = (flen_q > slen_q) ? flen_q : slen_q;

    a_dig = f_in_q ? f_rd_q : 4'd0;
    b_dig = s_in_q ? s_rd_q : 4'd0;
    hi_dig = first_larger_q ? a_dig : b_dig;
    lo_dig = first_larger_q ? b_dig : a_dig;
    sum = {1'b0, a_dig} + {1'b0, b_dig} + {4'd0, carry_q};
    sb  = {1'b0, lo_dig} + {4'd0, carry_q};
    if (!eff_sub_q) begin
      step_carry = (sum >= RADIX);
      step_digit = step_carry ? 4'(sum - RADIX) : sum[3:0];
    end else if ({1'b0, hi_dig} >= sb) begin
      step_carry = 1'b0;
      step_digit = 4'({1'b0, hi_dig} - sb);
    end else begin
      step_carry = 1'b1;
      step_digit = 4'({1'b0, hi_dig} + RADIX - sb);
    end

    // Result is zero when no digit was nonzero and, when adding, no carry came out on top.
    all_zero = !nonzero_q && !(!eff_sub_q && carry_q);
    res_neg  = (eff_sub_q ? (first_larger_q ? fneg_q : !fneg_q) : fneg_q) && !all_zero;
    out_free = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    state_d        = state_q;
    p_d            = p_q;
    flen_d         = flen_q;
    slen_d         = slen_q;
    wflen_d        = wflen_q;
    wslen_d        = wslen_q;
    n_d            = n_q;
    dropped_d      = dropped_q;
    fneg_d         = fneg_q;
    eff_sub_d      = eff_sub_q;
    ovf_d          = ovf_q;
    first_larger_d = first_larger_q;
    carry_d        = carry_q;
    nonzero_d      = nonzero_q;
    q_pop_o        = 1'b0;
    f_we           = 1'b0;
    s_we           = 1'b0;
    r_we           = 1'b0;
    r_wr_data      = step_digit;
    ld_addr        = '0;
    out_load       = 1'b0;
    out_item_d     = out_item_q;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.kind)
            CMD_LOAD_FIRST: begin
              ld_addr = flen_q[ADDR_W-1:0];
              if (flen_q < LEN_W'(MAX_DIGITS)) begin
                f_we   = 1'b1;
                flen_d = flen_q + LEN_W'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            CMD_LOAD_SECOND: begin
              ld_addr = slen_q[ADDR_W-1:0];
              if (slen_q < LEN_W'(MAX_DIGITS)) begin
                s_we   = 1'b1;
                slen_d = slen_q + LEN_W'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            CMD_COMPUTE: begin
              wflen_d   = flen_q;
              wslen_d   = slen_q;
              n_d       = max_len;
              fneg_d    = q_cmd_i.first_negative;
              eff_sub_d = q_cmd_i.first_negative ^ q_cmd_i.second_negative
                          ^ q_cmd_i.subtract;
              ovf_d     = dropped_q;
              flen_d    = '0;
              slen_d    = '0;
              dropped_d = 1'b0;
              carry_d   = 1'b0;
              nonzero_d = 1'b0;
              first_larger_d = 1'b0;
              if (max_len == '0) begin
                state_d = ST_EMIT_ZERO;
              end else if (q_cmd_i.first_negative ^ q_cmd_i.second_negative
                           ^ q_cmd_i.subtract) begin
                p_d     = ADDR_W'(max_len - LEN_W'(1));
                state_d = ST_CMP_RD;
              end else begin
                p_d     = '0;
                state_d = ST_ARI_RD;
              end
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_CMP_RD: begin
        state_d = ST_CMP_USE;
      end
      ST_CMP_USE: begin
        // Walk from the most significant aligned position to the first difference.
        if (a_dig != b_dig) begin
          first_larger_d = a_dig > b_dig;
          p_d            = '0;
          state_d        = ST_ARI_RD;
        end else if (p_q == '0) begin
          state_d = ST_ARI_RD;
        end else begin
          p_d     = p_q - ADDR_W'(1);
          state_d = ST_CMP_RD;
        end
      end
      ST_ARI_RD: begin
        state_d = ST_ARI_USE;
      end
      ST_ARI_USE: begin
        r_we      = 1'b1;
        carry_d   = step_carry;
        nonzero_d = nonzero_q || (step_digit != 4'd0);
        if (p_ext == n_minus1) begin
          state_d = ST_EMIT_START;
        end else begin
          p_d     = p_q + ADDR_W'(1);
          state_d = ST_ARI_RD;
        end
      end
      ST_EMIT_START: begin
        p_d = '0;
        if (eff_sub_q || !carry_q) begin
          state_d = ST_EMIT_RD;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_item_d = '{result_digit: 4'd1, negative: res_neg, last: 1'b0,
                         overflowed: ovf_q};
          state_d    = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LOAD;
      end
      ST_EMIT_LOAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_item_d = '{result_digit: r_rd_q, negative: res_neg,
                         last: (p_ext == n_minus1), overflowed: ovf_q};
          if (p_ext == n_minus1) begin
            state_d = ST_IDLE;
          end else begin
            p_d     = p_q + ADDR_W'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_ZERO: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_item_d = '{result_digit: 4'd0, negative: 1'b0, last: 1'b1,
                         overflowed: ovf_q};
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flen_q      <= '0;
      slen_q      <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flen_q      <= flen_d;
      slen_q      <= slen_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q            <= p_d;
    wflen_q        <= wflen_d;
    wslen_q        <= wslen_d;
    n_q            <= n_d;
    fneg_q         <= fneg_d;
    eff_sub_q      <= eff_sub_d;
    ovf_q          <= ovf_d;
    first_larger_q <= first_larger_d;
    carry_q        <= carry_d;
    nonzero_q      <= nonzero_d;
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      first_mem[ld_addr] <= q_cmd_i.digit;
    end
    f_rd_q <= first_mem[f_addr];
    f_in_q <= f_in;
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      second_mem[ld_addr] <= q_cmd_i.digit;
    end
    s_rd_q <= second_mem[s_addr];
    s_in_q <= s_in;
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      result_mem[r_wr_addr] <= r_wr_data;
    end
    r_rd_q <= result_mem[p_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: src/signed_decimal_add_subtract.sv
// Top level of the signed decimal add/subtract block.
//
// Usage: items arrive on the input channel (in_valid_i, in_stall_o, in_item_i).
// Mode 0 and mode 1 items append one decimal digit, most significant first, to
// the first or second magnitude; digits above nine are stored as nine, and a
// digit that finds its operand full is dropped and remembered as an overflow.
// A mode 2 item carries both signs and the add/subtract request and starts
// the calculation; mode 3 items are taken and ignored. Results leave on the
// output channel (out_valid_o, out_stall_i, out_item_o), one transfer per
// result digit, most significant first, with last on the final digit.
// Processing: a load item is handled in the idle state. A compute item over n
// digit positions first runs the magnitude compare (effective subtract
// only, stopping at the first differing digit), then the add or subtract
// walk, each digit step waiting on the registered read of the digit stores,
// then emits each result digit after a registered read of the result store.
// The front stage and a two-entry queue keep taking items while the back
// stage works or while the receiver stalls, until the queue fills; a stalled
// result holds in the output register. Reset empties the queue and clears
// both lengths and the overflow flag; the digit stores need no clearing.
module signed_decimal_add_subtract (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdas_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdas_pkg::out_item_t out_item_o
);
  import sdas_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t front_cmd, queue_cmd;

  // The front stage classifies each transfer into a load or compute command, or drops it.
  sdas_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (front_cmd)
  );

  // The queue lets the front keep accepting while the back stage is busy.
  sdas_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (queue_cmd)
  );

  // The back stage owns the digit stores and runs commands in order.
  sdas_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (queue_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
